// File: sv/lgas_pkg.sv
package lgas_pkg;

    localparam int AGE_W          = 3;
    localparam int GRID_WIDTH_W   = 11;
    localparam int GRID_HEIGHT_W  = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    // saturation point of the age counter
    localparam logic [7:0] AGE_CAP = 8'd7;

    // register values after reset, and the smallest legal grid side
    localparam int RESET_GRID_WIDTH  = 1024;
    localparam int RESET_GRID_HEIGHT = 768;
    localparam int MIN_GRID          = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic [AGE_W-1:0] t_age;

    // one window column: [0] top, [1] middle, [2] bottom
    typedef t_age [2:0] t_column;

    typedef struct packed {
        logic kind;
        t_age cell_age;
    } t_in;

    typedef struct packed {
        t_age next_age;
        logic frame_last;
    } t_out;

    // per-item control carried from the counter stage to the window stage
    typedef struct packed {
        t_age age;
        logic emit;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic last;
    } t_s1_ctl;

endpackage

// File: sv/lgas_ram.sv
module lgas_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]         i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]         i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/lgas_front.sv
module lgas_front #(
    parameter int MAX_WIDTH = lgas_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [lgas_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [lgas_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                   o_cfg_ready,
    input  logic                                   i_in_valid,
    input  lgas_pkg::t_in                          i_in_data,
    output logic                                   o_in_ready,
    input  logic                                   i_take,
    output logic                                   o_s1_valid,
    output lgas_pkg::t_s1_ctl                      o_s1,
    output logic                                   o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_rd_addr,
    output logic                                   o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_wr_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > lgas_pkg::GRID_WIDTH_W) ? WW : lgas_pkg::GRID_WIDTH_W;
    localparam int HW = lgas_pkg::GRID_HEIGHT_W;
    localparam int RESET_WIDTH_EFF = (lgas_pkg::RESET_GRID_WIDTH > MAX_WIDTH) ?
                                     MAX_WIDTH : lgas_pkg::RESET_GRID_WIDTH;

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;
    logic          r_s1_valid, n_s1_valid;
    lgas_pkg::t_s1_ctl r_s1, n_s1;
    logic [CW-1:0] r_s1_col;

    logic          cfg_acc, cfg_hit;
    logic          in_acc, in_load, s1_adv;
    logic          in_active, ignored;
    logic [EW-1:0] cfg_w_raw, cfg_w_clamp;
    logic [HW-1:0] cfg_h_clamp;
    logic [WW-1:0] in_col_inc, out_col_inc;
    logic [HW:0]   out_row_inc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_acc && ((i_cfg_index == lgas_pkg::CFG_GRID_WIDTH) ||
                                     (i_cfg_index == lgas_pkg::CFG_GRID_HEIGHT));

    assign cfg_w_raw   = EW'(i_cfg_data[lgas_pkg::GRID_WIDTH_W-1:0]);
    assign cfg_w_clamp = (cfg_w_raw < EW'(lgas_pkg::MIN_GRID)) ? EW'(lgas_pkg::MIN_GRID) :
                         (cfg_w_raw > EW'(MAX_WIDTH))          ? EW'(MAX_WIDTH) : cfg_w_raw;
    assign cfg_h_clamp = (i_cfg_data < HW'(lgas_pkg::MIN_GRID)) ? HW'(lgas_pkg::MIN_GRID) :
                         i_cfg_data;

    assign s1_adv     = r_s1_valid && i_take;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // drain ticks while the frame's rows are still coming in are swallowed
    assign in_active = r_in_row < r_height;
    assign ignored   = in_active && (i_in_data.kind == lgas_pkg::KIND_DRAIN);
    assign in_load   = in_acc && !ignored;

    assign in_col_inc  = WW'(r_in_col) + WW'(1);
    assign out_col_inc = WW'(r_out_col) + WW'(1);
    assign out_row_inc = {1'b0, r_out_row} + (HW+1)'(1);

    always_comb begin
        n_s1.age    = in_active ? i_in_data.cell_age : '0;
        n_s1.emit   = (r_in_row >= HW'(2)) || ((r_in_row == HW'(1)) && (r_in_col != '0));
        n_s1.top    = r_out_row != '0;
        n_s1.bottom = out_row_inc < {1'b0, r_height};
        n_s1.left   = r_out_col != '0;
        n_s1.right  = out_col_inc < r_width;
        n_s1.last   = n_s1.emit && !n_s1.bottom && !n_s1.right;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (in_load) begin
            if (n_s1.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (n_s1.emit) begin
                    if (n_s1.right) begin
                        n_out_col = CW'(out_col_inc);
                    end else begin
                        n_out_col = '0;
                        n_out_row = out_row_inc[HW-1:0];
                    end
                end
                if (in_col_inc >= r_width) begin
                    n_in_col = '0;
                    if (r_in_row != '1) begin
                        n_in_row = r_in_row + HW'(1);
                    end
                end else begin
                    n_in_col = CW'(in_col_inc);
                end
            end
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_load) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(RESET_WIDTH_EFF);
            r_height   <= HW'(lgas_pkg::RESET_GRID_HEIGHT);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    lgas_pkg::CFG_GRID_WIDTH:  r_width  <= WW'(cfg_w_clamp);
                    lgas_pkg::CFG_GRID_HEIGHT: r_height <= cfg_h_clamp;
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_s1     <= n_s1;
            r_s1_col <= r_in_col;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_rd_en    = in_load;
    assign o_rd_addr  = r_in_col;
    assign o_wr_en    = s1_adv;
    assign o_wr_addr  = r_s1_col;

    // counters stay inside the row
    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < r_width)
        else $error("input column beyond grid width");

    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_out_col) < r_width)
        else $error("output column beyond grid width");

    // a swallowed drain tick leaves the raster position alone
    a_ignored_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ignored && !cfg_acc) |=>
            ($stable(r_in_col) && $stable(r_in_row) && $stable(r_out_col)))
        else $error("ignored drain tick moved the counters");

endmodule

// File: sv/lgas_window.sv
module lgas_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  lgas_pkg::t_s1_ctl  i_s1,
    input  lgas_pkg::t_age     i_up,
    input  lgas_pkg::t_age     i_mid,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lgas_pkg::t_out     o_out_data
);

    lgas_pkg::t_column r_win [3];
    lgas_pkg::t_column new_col, c0, c1, c2;
    logic              r_out_valid;
    lgas_pkg::t_out    r_out_data, n_out_data;
    logic              adv;
    logic [7:0]        nb;
    logic [3:0]        n_alive;
    logic [3:0]        next_raw;
    logic [7:0]        next_cap;

    assign o_take = !r_out_valid || i_out_ready;
    assign adv    = i_s1_valid && o_take;

    always_comb begin
        new_col[0] = i_up;
        new_col[1] = i_mid;
        new_col[2] = i_s1.age;
    end

    // window after the shift: left, centre, right columns
    assign c0 = r_win[1];
    assign c1 = r_win[2];
    assign c2 = new_col;

    always_comb begin
        nb[0] = i_s1.left  && i_s1.top    && (c0[0] != '0);
        nb[1] = i_s1.left                 && (c0[1] != '0);
        nb[2] = i_s1.left  && i_s1.bottom && (c0[2] != '0);
        nb[3] = i_s1.top                  && (c1[0] != '0);
        nb[4] = i_s1.bottom               && (c1[2] != '0);
        nb[5] = i_s1.right && i_s1.top    && (c2[0] != '0);
        nb[6] = i_s1.right                && (c2[1] != '0);
        nb[7] = i_s1.right && i_s1.bottom && (c2[2] != '0);
    end

    always_comb begin
        n_alive = '0;
        for (int k = 0; k < 8; k++) begin
            n_alive = n_alive + 4'(nb[k]);
        end
    end

    always_comb begin
        next_raw = '0;
        if (c1[1] == '0) begin
            if (n_alive == 4'd3) begin
                next_raw = 4'd1;
            end
        end else if ((n_alive == 4'd2) || (n_alive == 4'd3)) begin
            next_raw = 4'(c1[1]) + 4'd1;
        end
        next_cap = (8'(next_raw) > lgas_pkg::AGE_CAP) ? lgas_pkg::AGE_CAP : 8'(next_raw);
        n_out_data.next_age   = next_cap[lgas_pkg::AGE_W-1:0];
        n_out_data.frame_last = i_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= new_col;
        end
        if (adv && i_s1.emit) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && i_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a dead centre can only be born, never aged
    a_birth_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_s1.emit && (c1[1] == '0)) |=>
            ((r_out_data.next_age == '0) || (r_out_data.next_age == 3'd1)))
        else $error("dead centre produced an aged cell");

    // a stage-one item waits while the result register is full
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s1_valid && !o_take) |=> i_s1_valid)
        else $error("stage-one item lost while stalled");

endmodule

// File: sv/life_generation_age_stencil.sv
// Life generation with cell ages (birth on 3, survival on 2 or 3), streamed in
// raster order, one cell age per input transfer and at most one result per
// transfer. Edge cells see dead neighbours; there is no wrap. A newborn gets
// age 1, a survivor its age plus one saturated at 7, everything else 0. The
// result for a cell appears one row plus one cell after its own transfer, so
// after the last cell of a frame send grid_width + 1 drain transfers
// (kind = 1) to flush the last row; drains sent earlier are swallowed. The
// result for the final cell carries frame_last, after which the next transfer
// starts a new frame. Throughput is one transfer per clock while the output
// side keeps up: a cell is registered into stage one as its two line-store
// reads are issued, the reads come back registered alongside it, and the 3x3
// window count and age rule sit between that stage and the result register.
// Writing grid_width (index 0) or grid_height (index 1)
// restarts the frame; write them only while the block is idle. Widths are
// clamped to 3..MAX_WIDTH and heights to at least 3.
module life_generation_age_stencil #(
    parameter int MAX_WIDTH = lgas_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lgas_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [lgas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lgas_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lgas_pkg::t_out                     o_out_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic              take;
    logic              s1_valid;
    lgas_pkg::t_s1_ctl s1;
    logic              rd_en, wr_en;
    logic [CW-1:0]     rd_addr, wr_addr;
    lgas_pkg::t_age    up_rd, mid_rd;

    // raster counters, edge flags and line-store read and write issue
    lgas_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .i_take      (take),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr)
    );

    // row two above: refilled from the middle store as the stream moves on
    lgas_ram #(
        .WIDTH (lgas_pkg::AGE_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (mid_rd),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (up_rd)
    );

    // row directly above: takes the incoming (or drained) age
    lgas_ram #(
        .WIDTH (lgas_pkg::AGE_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_middle (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (s1.age),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mid_rd)
    );

    // 3x3 window, neighbour count, age rule and result register
    lgas_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_up        (up_rd),
        .i_mid       (mid_rd),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/sv/life_stencil_checker.sv
module life_stencil_checker
    import lgas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  t_in                    i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  t_out                   i_out_data,
    output int                     o_pending,
    output int                     o_mismatches
);

    localparam int unsigned LINE_CELLS  = MAX_WIDTH_DEFAULT;
    localparam int unsigned ROW_CEILING = 65535;
    localparam int          BIRTH_COUNT = 3;
    localparam int          KEEP_COUNT  = 2;

    logic [GRID_WIDTH_W-1:0]  width_reg;
    logic [GRID_HEIGHT_W-1:0] height_reg;
    t_age                     upper_line  [LINE_CELLS];
    t_age                     middle_line [LINE_CELLS];
    t_column                  win_cols [3];   // [0] left .. [2] right
    int unsigned              in_col, in_row, out_col, out_row;
    t_out                     next_ages_q [$];
    int                       mismatch_count;

    function automatic int unsigned cols_in_use();
        int unsigned w;
        w = 32'(width_reg);
        if (w < MIN_GRID) w = MIN_GRID;
        if (w > LINE_CELLS) w = LINE_CELLS;
        return w;
    endfunction

    function automatic int unsigned rows_in_use();
        int unsigned h;
        h = 32'(height_reg);
        if (h < MIN_GRID) h = MIN_GRID;
        return h;
    endfunction

    task automatic restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    task automatic apply_write(input logic [CFG_INDEX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
        if (index == CFG_GRID_WIDTH) begin
            width_reg = data[GRID_WIDTH_W-1:0];
            restart_frame();
        end else if (index == CFG_GRID_HEIGHT) begin
            height_reg = data[GRID_HEIGHT_W-1:0];
            restart_frame();
        end
    endtask

    // one accepted item: shift the neighbourhood, maybe queue the next-generation age
    task automatic life_step(input t_in item);
        int unsigned w, h;
        t_age        age, up, mid, centre;
        t_column     nb [3];
        logic        emit, has_up, has_down, has_left, has_right, last;
        logic [3:0]  grown;
        int          n, c, r;
        t_out        res;

        w   = cols_in_use();
        h   = rows_in_use();
        age = item.cell_age;
        if (in_row < h) begin
            if (item.kind == KIND_DRAIN) return;
        end else begin
            age = '0;
        end

        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        up  = upper_line[in_col];
        mid = middle_line[in_col];
        upper_line[in_col]  = mid;
        middle_line[in_col] = age;

        // at column 0 the window still holds the previous row's right edge
        if (in_col == 0) begin
            nb[0] = win_cols[1];
            nb[1] = win_cols[2];
            nb[2] = '0;
        end
        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = {age, mid, up};
        if (in_col != 0) begin
            nb = win_cols;
        end

        if (emit) begin
            has_up    = out_row > 0;
            has_down  = out_row + 1 < h;
            has_left  = out_col > 0;
            has_right = out_col + 1 < w;
            centre    = nb[1][1];
            n         = 0;
            for (c = 0; c < 3; c++) begin
                for (r = 0; r < 3; r++) begin
                    if (c == 1 && r == 1) continue;
                    if (c == 0 && !has_left) continue;
                    if (c == 2 && !has_right) continue;
                    if (r == 0 && !has_up) continue;
                    if (r == 2 && !has_down) continue;
                    if (nb[c][r] != '0) n++;
                end
            end

            if (centre == '0) begin
                res.next_age = (n == BIRTH_COUNT) ? t_age'(1) : t_age'(0);
            end else if (n == KEEP_COUNT || n == BIRTH_COUNT) begin
                grown = {1'b0, centre} + 4'd1;
                res.next_age = (grown > AGE_CAP) ? AGE_CAP[AGE_W-1:0] : grown[AGE_W-1:0];
            end else begin
                res.next_age = '0;
            end

            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.frame_last = last;
            next_ages_q.push_back(res);

            if (last) begin
                restart_frame();
                return;
            end
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end

        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < ROW_CEILING) in_row++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            width_reg  = GRID_WIDTH_W'(RESET_GRID_WIDTH);
            height_reg = GRID_HEIGHT_W'(RESET_GRID_HEIGHT);
            foreach (upper_line[k]) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            win_cols = '{default: '0};
            restart_frame();
            next_ages_q.delete();
            mismatch_count = 0;
        end else begin
            // compare first: a result never leaves in the cycle its cell arrives
            if (i_out_valid && i_out_ready) begin
                if (next_ages_q.size() == 0) begin
                    $error("unexpected result: next_age %0d frame_last %0d",
                           i_out_data.next_age, i_out_data.frame_last);
                    mismatch_count++;
                end else begin
                    want = next_ages_q.pop_front();
                    if (i_out_data.next_age !== want.next_age) begin
                        $error("next_age: expected %0d, got %0d",
                               want.next_age, i_out_data.next_age);
                        mismatch_count++;
                    end
                    if (i_out_data.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, i_out_data.frame_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) life_step(i_in_data);
        end
        o_pending    <= next_ages_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// File: tb/sv/tb_life_generation_age_stencil.sv
// Stimulus and verdict only; the checker beside the block does the prediction.
module tb_life_generation_age_stencil;
    import lgas_pkg::*;

    localparam int  CLK_PERIOD    = 12;
    localparam int  RESET_CYCLES  = 6;
    localparam int  RANDOM_CELLS  = 480;
    localparam int  SETTLE_CYCLES = 16;   // generous margin for the pipeline to empty
    localparam int  END_CYCLES    = 40;
    localparam int  HOLD_CYCLES   = 400;  // long output stall, enough to back up the input
    localparam int  WIDE_CELLS    = MAX_WIDTH_DEFAULT + 200;
    localparam int  TIMEOUT_UNITS = 40_000_000;

    // register indexes the block does not decode; writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in                    in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out                   out_data;

    int   pending;
    int   mismatches;
    int   cells_sent = 0;
    int   calm_in    = 0;     // transfers left in a gap-free run on the input side
    logic hold_req   = 1'b0;  // asks the output side for one long stall

    // 3x3 seed: a 7 that saturates, a 6 that reaches the cap, a birth in the centre
    t_age seed_grid [9] = '{3'd7, 3'd7, 3'd0,
                            3'd6, 3'd0, 3'd0,
                            3'd0, 3'd0, 3'd0};

    always #(CLK_PERIOD / 2) clk = ~clk;

    life_generation_age_stencil dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    life_stencil_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // mostly short gaps, the odd long one
    function automatic int idle_gap();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic t_age pick_age(input int density);
        if ($urandom_range(0, 99) < density) return t_age'($urandom_range(1, AGE_CAP));
        return '0;
    endfunction

    function automatic int fit_width(input logic [GRID_WIDTH_W-1:0] raw);
        if (raw < MIN_GRID) return MIN_GRID;
        if (raw > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
        return int'(raw);
    endfunction

    function automatic int fit_height(input logic [GRID_HEIGHT_W-1:0] raw);
        return (raw < MIN_GRID) ? MIN_GRID : int'(raw);
    endfunction

    // Offer one item and hold it until the transfer; valid stays up into the
    // next item unless a gap is drawn, so it is never dropped and raised in
    // the same step.
    task automatic send_item(input logic item_kind, input t_age item_age);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{item_kind, item_age};
        do @(posedge clk); while (!in_ready);
        if (calm_in > 0) begin
            calm_in--;
        end else if ($urandom_range(0, 3) == 0) begin
            gap = idle_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end else if ($urandom_range(0, 99) == 0) begin
            calm_in = $urandom_range(50, 400);
        end
    endtask

    // leaves cfg_valid high so that back-to-back writes need not drop and raise it again
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Both geometry registers, in random order, now and then after a spare-index write; unused width bits carry noise.
    task automatic configure(input logic [GRID_WIDTH_W-1:0] w_raw,
                             input logic [GRID_HEIGHT_W-1:0] h_raw);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[GRID_WIDTH_W-1:0] = w_raw;
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_GRID_WIDTH, word);
            write_reg(CFG_GRID_HEIGHT, h_raw);
        end else begin
            write_reg(CFG_GRID_HEIGHT, h_raw);
            write_reg(CFG_GRID_WIDTH, word);
        end
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: the checker first counts the last transfer, then every
    // queued result must drain; the settle covers items still in the pipe
    // that make no result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame of random cells. A broken frame stops part way and skips the
    // flush; the next frame or write simply carries on from there. Early
    // drains are scattered in as noise and must be swallowed.
    task automatic send_frame(input int w, input int h, input int density,
                              input bit broken);
        int cells;
        cells = broken ? $urandom_range(1, w * h - 1) : w * h;
        for (int i = 0; i < cells; i++) begin
            if ($urandom_range(0, 23) == 0) send_item(KIND_DRAIN, t_age'($urandom));
            send_item(KIND_CELL, pick_age(density));
            cells_sent++;
        end
        if (!broken) begin
            // flush one row plus one cell; a cell here counts as a drain
            for (int i = 0; i <= w; i++)
                send_item(1'($urandom_range(0, 1)), t_age'($urandom));
            if ($urandom_range(0, 9) == 0) send_item(KIND_DRAIN, t_age'($urandom));
        end
    endtask

    // Output side: random stalls, gap-free stretches, and the one long hold,
    // counted here while the sender keeps offering.
    initial begin : out_side
        int  stall_left;
        int  calm;
        bit  hold_taken;
        stall_left = 0;
        calm       = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = idle_gap();
                end else if ($urandom_range(0, 99) == 0) begin
                    calm = $urandom_range(50, 400);
                end
            end
        end
    end

    initial begin : stimulus
        int                       w, h;
        int                       frames;
        logic [GRID_WIDTH_W-1:0]  w_raw;
        logic [GRID_HEIGHT_W-1:0] h_raw;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: smallest grid, hand-made seed ---
        configure(11'd3, 16'd3);
        for (int i = 0; i < 9; i++) begin
            send_item(KIND_CELL, seed_grid[i]);
            if (i == 4) begin
                // pause mid-frame until the first results are out, poke the
                // undecoded indexes, then a drain that is too early to count
                wait_idle();
                write_reg(CFG_SPARE_LO, '1);
                write_reg(CFG_SPARE_HI, '1);
                cfg_valid <= 1'b0;
                send_item(KIND_DRAIN, 3'd7);
            end
        end
        // flush: cells after the frame act as drains, their age dropped
        send_item(KIND_CELL, 3'd5);
        send_item(KIND_CELL, 3'd5);
        send_item(KIND_DRAIN, 3'd2);
        send_item(KIND_DRAIN, 3'd2);
        // start a frame, abandon it, and restart with out-of-range geometry
        for (int i = 0; i < 3; i++) send_item(KIND_CELL, 3'd7);
        wait_idle();
        configure(11'd1, 16'd0);
        w = MIN_GRID;
        h = MIN_GRID;

        // --- random: mostly small grids, now and then the clamped edges ---
        while (cells_sent < RANDOM_CELLS) begin
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                send_frame(w, h, $urandom_range(0, 100), $urandom_range(0, 9) == 0);
            wait_idle();
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       w_raw = GRID_WIDTH_W'($urandom_range(0, MIN_GRID));
                    1:       w_raw = GRID_WIDTH_W'($urandom_range(13, 40));
                    default: w_raw = GRID_WIDTH_W'($urandom_range(3, 6));
                endcase
                h_raw = ($urandom_range(0, 1)) ? GRID_HEIGHT_W'($urandom_range(0, MIN_GRID))
                                              : GRID_HEIGHT_W'($urandom_range(9, 20));
            end else begin
                w_raw = GRID_WIDTH_W'($urandom_range(3, 12));
                h_raw = GRID_HEIGHT_W'($urandom_range(3, 8));
            end
            configure(w_raw, h_raw);
            w = fit_width(w_raw);
            h = fit_height(h_raw);
        end

        // --- widest rows, tallest frame: part of a frame, with the long hold ---
        wait_idle();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(RESET_GRID_WIDTH));
        configure('1, '1);   // width clamps to the line store size
        for (int i = 0; i < WIDE_CELLS; i++) begin
            if (i == MAX_WIDTH_DEFAULT + 80) hold_req <= 1'b1;
            send_item(KIND_CELL, pick_age(40));
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("life_generation_age_stencil: match");
        end else begin
            $display("life_generation_age_stencil: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #(TIMEOUT_UNITS);
        $display("life_generation_age_stencil: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/lgas_pkg.sv
sv/lgas_ram.sv
sv/lgas_front.sv
sv/lgas_window.sv
sv/life_generation_age_stencil.sv
tb/sv/life_stencil_checker.sv
tb/sv/tb_life_generation_age_stencil.sv
